### src/ptn_pkg.sv
// ----------------------------------------------------------------------------
// ptn_pkg: shared types and helpers for the punctuation text normalizer
// Beat structs for both channels, character codes and byte classification.
// ----------------------------------------------------------------------------
package ptn_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_HYPH  = 8'h2D;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_char;
        logic       end_of_sentence;
    } t_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Map byte c given its neighbors p (before) and n (after).
    function automatic logic [7:0] map_byte(input logic [7:0] p,
                                            input logic [7:0] c,
                                            input logic [7:0] n);
        logic [7:0] m;
        m = CH_SPACE;
        if (is_alnum(c)) begin
            m = c;
        end else if (c == CH_APOS && is_letter(p) && is_letter(n)) begin
            m = c;
        end else if (c == CH_HYPH && is_alnum(p) && is_alnum(n)) begin
            m = c;
        end
        return m;
    endfunction

endpackage

### src/punctuation_text_normalizer.sv
// ----------------------------------------------------------------------------
// punctuation_text_normalizer
// Cleans a byte stream sentence by sentence: keeps letters and digits, keeps
// inner apostrophes and hyphens, collapses and strips spaces.
// ----------------------------------------------------------------------------
// One input beat is accepted per cycle and its results are written the same
// cycle into a four-entry result queue that drives the output port, one
// result per cycle while i_out_ready is high. A beat yields zero to three
// results; input ready is high while the queue holds at most one result, so
// a beat that yields one result or none sustains one beat per cycle while
// results drain, and the output port sets the rate otherwise. A result is in
// the queue the cycle after its beat; since each byte waits for its successor,
// a character comes out with the beat that follows it, or with the last beat.
module punctuation_text_normalizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptn_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ptn_pkg::t_out  o_out
);

    localparam int QDEPTH = 4;

    // sentence state
    logic [7:0] r_prev_byte, n_prev_byte;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic       r_space_owed, n_space_owed;
    logic       r_word_seen, n_word_seen;

    // result queue, head at entry 0
    ptn_pkg::t_out r_q [QDEPTH];
    ptn_pkg::t_out n_q [QDEPTH];
    logic [2:0]    r_cnt, n_cnt;

    logic          accept, pop;
    ptn_pkg::t_out res [3];
    logic [2:0]    nres;

    assign o_in_ready  = (r_cnt <= 3'd1);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out       = r_q[0];
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    // classify the held byte against the new one, then the last byte
    always_comb begin
        logic [7:0] b;
        logic [7:0] m1;
        logic       c1, s1, c2, s2, owed1, word1, marker;
        logic [7:0] prev1;
        logic       cv [5];
        logic [7:0] cb [5];

        b     = i_in.in_byte;
        m1    = ptn_pkg::map_byte(r_prev_byte, r_held_byte, b);
        c1    = r_held_valid && (m1 != ptn_pkg::CH_SPACE);
        s1    = c1 && r_space_owed;
        owed1 = r_space_owed;
        word1 = r_word_seen;
        prev1 = r_prev_byte;
        if (r_held_valid) begin
            owed1 = c1 ? 1'b0 : (r_space_owed || r_word_seen);
            word1 = r_word_seen || c1;
            prev1 = r_held_byte;
        end
        // the byte after the last counts as none, so only alnum survives
        c2     = i_in.in_last && ptn_pkg::is_alnum(b);
        s2     = c2 && owed1;
        marker = i_in.in_last && !c1 && !c2;

        cv[0] = s1;     cb[0] = ptn_pkg::CH_SPACE;
        cv[1] = c1;     cb[1] = m1;
        cv[2] = s2;     cb[2] = ptn_pkg::CH_SPACE;
        cv[3] = c2;     cb[3] = b;
        cv[4] = marker; cb[4] = ptn_pkg::CH_NONE;

        nres = 3'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end
        for (int j = 0; j < 5; j++) begin
            if (cv[j] && nres != 3'd3) begin
                res[nres[1:0]].out_byte = cb[j];
                res[nres[1:0]].has_char = (j != 4);
                nres = nres + 3'd1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i].end_of_sentence = i_in.in_last && (nres == 3'(i + 1));
        end

        if (i_in.in_last) begin
            n_prev_byte  = ptn_pkg::CH_NONE;
            n_held_byte  = ptn_pkg::CH_NONE;
            n_held_valid = 1'b0;
            n_space_owed = 1'b0;
            n_word_seen  = 1'b0;
        end else begin
            n_prev_byte  = prev1;
            n_held_byte  = b;
            n_held_valid = 1'b1;
            n_space_owed = owed1;
            n_word_seen  = word1;
        end
    end

    // shift out on pop, append new results behind what remains
    always_comb begin
        logic [2:0] base;
        logic [2:0] k;
        logic [2:0] rel;

        base = r_cnt - {2'b00, pop};
        k    = accept ? nres : 3'd0;
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            rel = 3'(i) - base;
            if (3'(i) >= base && 3'(i) < base + k) begin
                n_q[i] = res[rel[1:0]];
            end
        end
        n_cnt = base + k;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
        if (!i_rst_n) begin
            r_cnt        <= 3'd0;
            r_prev_byte  <= ptn_pkg::CH_NONE;
            r_held_byte  <= ptn_pkg::CH_NONE;
            r_held_valid <= 1'b0;
            r_space_owed <= 1'b0;
            r_word_seen  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_prev_byte  <= n_prev_byte;
                r_held_byte  <= n_held_byte;
                r_held_valid <= n_held_valid;
                r_space_owed <= n_space_owed;
                r_word_seen  <= n_word_seen;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.in_last |=> !r_held_valid && !r_word_seen && !r_space_owed)
        else $error("sentence state not cleared after last beat");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.in_last |=> o_out_valid)
        else $error("last beat produced no result");

    a_owed_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space_owed |-> r_word_seen)
        else $error("space owed before any word");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.has_char |->
            o_out.out_byte == ptn_pkg::CH_NONE && o_out.end_of_sentence)
        else $error("malformed end marker");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for punctuation_text_normalizer
// Sends sentences byte by byte and predicts the cleaned output in the bench.
// The checker compares each output beat with the oldest predicted result.
// Directed sentences cover the edge cases first. Random text then runs under
// four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    ptn_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    ptn_pkg::t_out o_out;

    punctuation_text_normalizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // predicted cleaned characters, oldest first
    ptn_pkg::t_out clean_q[$];

    // bench copy of the normalizer state
    logic [7:0] prev_char;
    logic [7:0] hold_char;
    logic       hold_valid;
    logic       gap_pending;
    logic       seen_word;
    int         beat_chars;

    int send_idle_pct;
    int sink_stall_pct;
    int n_beats;
    int n_sentences;
    int n_checked;
    int n_errors;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results still pending", clean_q.size());
        $display("** punctuation_text_normalizer: FAILED **");
        $finish;
    end

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return alpha_char(c) || (c >= "0" && c <= "9");
    endfunction

    // Keep letters and digits; keep apostrophes between letters and hyphens
    // between letters or digits; turn everything else into a space.
    function automatic logic [7:0] clean_char(input logic [7:0] before_c,
                                              input logic [7:0] c,
                                              input logic [7:0] after_c);
        if (word_char(c))
            return c;
        if (c == ptn_pkg::CH_APOS && alpha_char(before_c) && alpha_char(after_c))
            return c;
        if (c == ptn_pkg::CH_HYPH && word_char(before_c) && word_char(after_c))
            return c;
        return ptn_pkg::CH_SPACE;
    endfunction

    task automatic push_clean(input logic [7:0] m);
        ptn_pkg::t_out r;
        if (m == ptn_pkg::CH_SPACE) begin
            if (seen_word)
                gap_pending = 1'b1;
            return;
        end
        r = '0;
        r.has_char = 1'b1;
        if (gap_pending) begin
            r.out_byte = ptn_pkg::CH_SPACE;
            clean_q.push_back(r);
            beat_chars++;
            gap_pending = 1'b0;
        end
        r.out_byte = m;
        clean_q.push_back(r);
        beat_chars++;
        seen_word = 1'b1;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic is_last);
        ptn_pkg::t_out r;
        beat_chars = 0;
        if (hold_valid) begin
            push_clean(clean_char(prev_char, hold_char, b));
            prev_char = hold_char;
        end
        hold_char  = b;
        hold_valid = 1'b1;
        if (is_last) begin
            push_clean(clean_char(prev_char, hold_char, ptn_pkg::CH_NONE));
            if (beat_chars == 0) begin
                r = '0;
                r.out_byte = ptn_pkg::CH_NONE;
            end else begin
                r = clean_q.pop_back();
            end
            r.end_of_sentence = 1'b1;
            clean_q.push_back(r);
            prev_char   = ptn_pkg::CH_NONE;
            hold_char   = ptn_pkg::CH_NONE;
            hold_valid  = 1'b0;
            gap_pending = 1'b0;
            seen_word   = 1'b0;
            n_sentences++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic [7:0] b, input logic is_last);
        ptn_pkg::t_in beat;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        beat.in_byte = b;
        beat.in_last = is_last;
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_beat(b, is_last);
        n_beats++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == s.len() - 1);
    endtask

    task automatic set_pressure(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
    endtask

    // Low control byte and 0xFF alone give bare end markers; a letter alone
    // ends its own sentence.
    task automatic test_lone_bytes();
        send_text("\001");
        send_text("\377");
        send_text("Q");
    endtask

    // Apostrophe kept between letters, dropped after a digit.
    task automatic test_apostrophe();
        send_text("z'A");
        send_text("9'a");
    endtask

    // Hyphen kept between alnum, dropped at the sentence end.
    task automatic test_hyphen();
        send_text("0-Z-");
    endtask

    // Leading junk, a high byte, DEL and a three-result beat.
    task automatic test_spacing();
        send_text(" \t-Zz\200\1770");
        send_text("a b1");
    endtask

    function automatic logic [7:0] rand_text_byte();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 20) return 8'("A" + $urandom_range(25));
        if (k < 38) return 8'("a" + $urandom_range(25));
        if (k < 52) return 8'("0" + $urandom_range(9));
        if (k < 64) return ptn_pkg::CH_SPACE;
        if (k < 74) return ptn_pkg::CH_APOS;
        if (k < 84) return ptn_pkg::CH_HYPH;
        return 8'($urandom_range(255, 1));
    endfunction

    // Mostly word-like sentences; about one in eight is raw byte noise.
    task automatic test_random_text(input int n_items, input int idle_pct,
                                    input int stall_pct);
        int sent;
        int len;
        logic noise;
        logic [7:0] b;
        set_pressure(idle_pct, stall_pct);
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(24, 10)
                                             : $urandom_range(8, 1);
            noise = ($urandom_range(7) == 0);
            for (int i = 0; i < len; i++) begin
                b = noise ? 8'($urandom_range(255, 1)) : rand_text_byte();
                send_beat(b, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $realtime, field, want, got);
        n_errors++;
    endtask

    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin : result_check
        ptn_pkg::t_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (clean_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual 0x%0h",
                             $realtime, o_out);
                    n_errors++;
                end else begin
                    want = clean_q.pop_front();
                    n_checked++;
                    if (o_out.out_byte !== want.out_byte)
                        report_field("out_byte", want.out_byte, o_out.out_byte);
                    if (o_out.has_char !== want.has_char)
                        report_field("has_char", want.has_char, o_out.has_char);
                    if (o_out.end_of_sentence !== want.end_of_sentence)
                        report_field("end_of_sentence", want.end_of_sentence,
                                     o_out.end_of_sentence);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        prev_char   = ptn_pkg::CH_NONE;
        hold_char   = ptn_pkg::CH_NONE;
        hold_valid  = 1'b0;
        gap_pending = 1'b0;
        seen_word   = 1'b0;
        n_beats     = 0;
        n_sentences = 0;
        n_checked   = 0;
        n_errors    = 0;
        set_pressure(0, 0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_lone_bytes();
        test_apostrophe();
        test_hyphen();
        test_spacing();

        test_random_text(20, 0, 0);
        test_random_text(20, 71, 0);
        test_random_text(20, 0, 71);
        test_random_text(20, 16, 16);

        // drop valid, open the sink and drain
        i_in_valid <= 1'b0;
        set_pressure(0, 0);
        while (clean_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d sentences, checked %0d output beats",
                 n_beats, n_sentences, n_checked);
        $display("Directed edge cases plus random text under four idle/stall mixes");
        if (n_errors == 0) begin
            $display("** punctuation_text_normalizer: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** punctuation_text_normalizer: FAILED **");
        end
        $finish;
    end

endmodule
